[rtl/i2cse_pkg.sv]
// Shared types and constants of the I2C master sequence engine.
`default_nettype none

package i2cse_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_GO    = 2'd1,
    OP_EVENT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_OTHER   = 2'd3;

  localparam logic [3:0] CNT_NONE = 4'd0;
  localparam logic [3:0] CNT_BIT  = 4'd1;
  localparam logic [3:0] CNT_BYTE = 4'd8;

  localparam logic REG_WAKE_ENABLE = 1'b0;

  localparam int ENTRY_W = 10;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_ACKSLOT = 3'd2,
    PH_CHECK   = 3'd3,
    PH_GOTDATA = 3'd4,
    PH_PRESTOP = 3'd5,
    PH_STOP    = 3'd6
  } phase_t;

  typedef struct packed {
    logic       sda_drive;
    logic [7:0] load_byte;
    logic [3:0] bit_count;
    logic       start_cond;
    logic       stop_release;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       nack_seen;
    logic       done_res;
    logic       wake;
    logic       rejected;
  } res_t;

  typedef struct packed {
    phase_t phase_next;
    logic   rp_inc;
    logic   rp_clear;
    logic   fc_inc;
    logic   fc_clear;
    logic   mem_we;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/i2cse_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module i2cse_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/i2cse_step.sv]
// Step logic: decodes one item against the current phase and stored entry.
`default_nettype none

module i2cse_step (
  input  wire logic                    [1:0] op,
  input  wire logic                    [7:0] shifted_byte,
  input  wire i2cse_pkg::phase_t             phase,
  input  wire logic                          have_entry,
  input  wire logic                          room,
  input  wire logic [i2cse_pkg::ENTRY_W-1:0] entry,
  input  wire logic                          wake_enable,
  output i2cse_pkg::res_t                    res,
  output i2cse_pkg::ctl_t                    ctl
);
  import i2cse_pkg::*;

  phase_t     nx_phase;
  logic       nx_sda;
  logic [7:0] nx_load;
  logic [3:0] nx_cnt;
  logic       ack_nack;

  assign ack_nack = shifted_byte[0];

  // Issue of the entry at the read pointer, or STOP when the sequence is exhausted.
  always_comb begin
    if (!have_entry) begin
      nx_phase = PH_STOP;
      nx_sda   = 1'b1;
      nx_load  = 8'h00;
      nx_cnt   = CNT_BIT;
    end else if (entry[9:8] == KIND_RESTART) begin
      nx_phase = PH_START;
      nx_sda   = 1'b1;
      nx_load  = 8'hff;
      nx_cnt   = CNT_BIT;
    end else if (entry[9:8] == KIND_READ) begin
      nx_phase = PH_GOTDATA;
      nx_sda   = 1'b0;
      nx_load  = 8'h00;
      nx_cnt   = CNT_BYTE;
    end else begin
      nx_phase = PH_ACKSLOT;
      nx_sda   = 1'b1;
      nx_load  = entry[7:0];
      nx_cnt   = CNT_BYTE;
    end
  end

  // Next phase and bookkeeping.
  always_comb begin
    ctl            = '0;
    ctl.phase_next = phase;
    case (op_t'(op))
      OP_LOAD: begin
        ctl.mem_we = (phase == PH_IDLE) && room;
        ctl.fc_inc = (phase == PH_IDLE) && room;
      end
      OP_GO: begin
        if (phase == PH_IDLE) begin
          ctl.phase_next = nx_phase;
          ctl.rp_inc     = have_entry;
        end
      end
      OP_EVENT: begin
        case (phase)
          PH_START: begin
            ctl.phase_next = nx_phase;
            ctl.rp_inc     = have_entry;
          end
          PH_ACKSLOT: ctl.phase_next = PH_CHECK;
          PH_CHECK: begin
            if (ack_nack) begin
              ctl.phase_next = PH_STOP;
            end else begin
              ctl.phase_next = nx_phase;
              ctl.rp_inc     = have_entry;
            end
          end
          PH_GOTDATA: ctl.phase_next = have_entry ? PH_CHECK : PH_PRESTOP;
          PH_PRESTOP: ctl.phase_next = PH_STOP;
          PH_STOP: begin
            ctl.phase_next = PH_IDLE;
            ctl.fc_clear   = 1'b1;
            ctl.rp_clear   = 1'b1;
          end
          default: ctl.phase_next = phase;
        endcase
      end
      default: ctl.phase_next = phase;
    endcase
  end

  // Result fields; anything a step does not set stays zero.
  always_comb begin
    res = '0;
    case (op_t'(op))
      OP_LOAD: res.rejected = (phase != PH_IDLE) || !room;
      OP_GO: begin
        if (phase != PH_IDLE) begin
          res.rejected = 1'b1;
        end else begin
          res.start_cond = 1'b1;
          res.sda_drive  = nx_sda;
          res.load_byte  = nx_load;
          res.bit_count  = nx_cnt;
        end
      end
      OP_EVENT: begin
        case (phase)
          PH_START: begin
            res.start_cond = 1'b1;
            res.sda_drive  = nx_sda;
            res.load_byte  = nx_load;
            res.bit_count  = nx_cnt;
          end
          PH_ACKSLOT: res.bit_count = CNT_BIT;
          PH_CHECK: begin
            if (ack_nack) begin
              res.nack_seen = 1'b1;
              res.sda_drive = 1'b1;
              res.load_byte = 8'h00;
              res.bit_count = CNT_BIT;
            end else begin
              res.sda_drive = nx_sda;
              res.load_byte = nx_load;
              res.bit_count = nx_cnt;
            end
          end
          PH_GOTDATA: begin
            res.rx_byte   = shifted_byte;
            res.rx_valid  = 1'b1;
            res.sda_drive = 1'b1;
            res.bit_count = CNT_BIT;
            // ACK while entries remain, NACK on the last read.
            res.load_byte = have_entry ? 8'h00 : 8'hff;
          end
          PH_PRESTOP: begin
            res.sda_drive = 1'b1;
            res.load_byte = 8'h00;
            res.bit_count = CNT_BIT;
          end
          PH_STOP: begin
            res.load_byte    = 8'hff;
            res.stop_release = 1'b1;
            res.done_res     = 1'b1;
            res.wake         = wake_enable;
          end
          default: res = '0;
        endcase
      end
      default: res = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/i2c_master_sequence_engine_top.sv]
// Top level of the I2C master sequence engine: store, state registers, ports.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------------
//  s_       | in  | s_tvalid/tready  | tuser op, entry_kind; tdata bytes
//  m_       | out | m_tvalid/tready  | tdata: one result per accepted item
//  APB      | in  | psel/penable     | wake_enable at byte address 0
//
// One item is accepted per cycle unless stalled; its result is registered.
// The store is read every cycle at the next read pointer, so the entry of
// the following item is ready; a load to that same address is forwarded.
// Reset is synchronous; no clearing pass of the store.
// A stalled result holds in the output register and blocks new items.
`default_nettype none

module i2c_master_sequence_engine_top #(
  parameter int SEQ_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // entry_byte[7:0], shifted_byte[15:8]
  input  wire logic [3:0]  s_tuser,   // op[1:0], entry_kind[3:2]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // sda_drive[0], load_byte[8:1], bit_count[12:9], start_cond[13],
  // stop_release[14], rx_byte[22:15], rx_valid[23], nack_seen[24],
  // done_res[25], wake[26], rejected[27], zeros[31:28]
  output logic [31:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import i2cse_pkg::*;

  localparam int AW = $clog2(SEQ_DEPTH);
  localparam int CW = $clog2(SEQ_DEPTH + 1);

  phase_t               phase;
  logic [CW-1:0]        fill_count;
  logic [CW-1:0]        read_pointer;
  logic [CW-1:0]        read_pointer_next;
  logic                 wake_enable;
  res_t                 out_res;
  res_t                 res;
  ctl_t                 ctl;
  logic                 accept;
  logic [1:0]           store_kind;
  logic [ENTRY_W-1:0]   wr_entry;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic                 fwd_hit;
  logic [ENTRY_W-1:0]   fwd_data;
  logic [ENTRY_W-1:0]   entry;
  logic                 have_entry;
  logic                 room;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign have_entry = read_pointer < fill_count;
  assign room       = fill_count < CW'(SEQ_DEPTH);
  assign entry      = fwd_hit ? fwd_data : ram_rdata;

  i2cse_step u_step (
    .op           (s_tuser[1:0]),
    .shifted_byte (s_tdata[15:8]),
    .phase        (phase),
    .have_entry   (have_entry),
    .room         (room),
    .entry        (entry),
    .wake_enable  (wake_enable),
    .res          (res),
    .ctl          (ctl)
  );

  // An unknown kind is stored as a write byte.
  assign store_kind = (s_tuser[3:2] == KIND_OTHER) ? KIND_WRITE : s_tuser[3:2];
  assign wr_entry   = {store_kind, s_tdata[7:0]};
  assign we         = accept && ctl.mem_we;
  assign waddr      = fill_count[AW-1:0];

  always_comb begin
    read_pointer_next = read_pointer;
    if (accept && ctl.rp_clear) begin
      read_pointer_next = '0;
    end else if (accept && ctl.rp_inc) begin
      read_pointer_next = read_pointer + CW'(1);
    end
  end

  assign raddr = (read_pointer_next < CW'(SEQ_DEPTH)) ? read_pointer_next[AW-1:0] : '0;

  i2cse_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SEQ_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      fill_count   <= '0;
      read_pointer <= '0;
      m_tvalid     <= 1'b0;
      fwd_hit      <= 1'b0;
    end else begin
      read_pointer <= read_pointer_next;
      fwd_hit      <= we && (waddr == raddr);
      if (accept) begin
        phase <= ctl.phase_next;
        if (ctl.fc_clear) begin
          fill_count <= '0;
        end else if (ctl.fc_inc) begin
          fill_count <= fill_count + CW'(1);
        end
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr_entry;
    if (accept) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'b0000, out_res.rejected, out_res.wake, out_res.done_res,
                    out_res.nack_seen, out_res.rx_valid, out_res.rx_byte,
                    out_res.stop_release, out_res.start_cond, out_res.bit_count,
                    out_res.load_byte, out_res.sda_drive};

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WAKE_ENABLE)) begin
      wake_enable <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_WAKE_ENABLE) ? {31'b0, wake_enable} : 32'b0;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(SEQ_DEPTH))
    else $error("fill count beyond store depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    read_pointer <= fill_count)
    else $error("read pointer passed fill count");

  a_idle_ptr: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> read_pointer == '0)
    else $error("read pointer not zero while idle");

  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    we |-> phase == PH_IDLE)
    else $error("store written while a transfer sequence runs");

  a_done_empties: assert property (@(posedge clk) disable iff (rst)
    accept && res.done_res |=> phase == PH_IDLE && fill_count == '0)
    else $error("completion did not return to idle with an empty store");
`endif

endmodule

`default_nettype wire
